// ----- rtl/core/gwsr_pkg.sv -----
`default_nettype none

package gwsr_pkg;

    // Store geometry
    localparam int DATA_W    = 32;
    localparam int MAX_WORDS = 32;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    // Logical word index: one extra bit flags taps and targets beyond the store
    localparam int IDX_W     = ADDR_W + 1;

    // Field and register widths
    localparam int SHIFT_W     = 6;
    localparam int GEN_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int LOAD_IDX_W  = 5;
    localparam int IN_FIELDS_W = LOAD_IDX_W + DATA_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Sequencer counts: five tap reads, three calc stages, four write slots
    localparam int TAP_COUNT   = 5;
    localparam int CALC_STAGES = 3;
    localparam int WR_SLOTS    = 4;
    localparam int CNT_W       = $clog2(TAP_COUNT + 1);

    typedef enum logic [GEN_W-1:0] {
        GEN_NONE,
        GEN_T1,
        GEN_T2,
        GEN_T3
    } t_gen;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEN_TYPE,
        CFG_WORD_COUNT,
        CFG_MIDDLE_TAP,
        CFG_SHIFT_A,
        CFG_SHIFT_B,
        CFG_SHIFT_C,
        CFG_SHIFT_D,
        CFG_TWIST_MASK
    } t_cfg_reg;

    typedef enum logic [2:0] {
        TAP_V0,
        TAP_VM,
        TAP_VN,
        TAP_VN1,
        TAP_VN2
    } t_tap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_CALC,
        ST_WRITE,
        ST_FETCH,
        ST_OUT
    } t_state;

    // Sequencer to word store
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [DATA_W-1:0] wr_data;
        logic              advance;
    } t_store_ctl;

    // Sequencer to recurrence datapath
    typedef struct packed {
        logic       cap_en;
        t_tap       cap_tap;
        logic       calc_en;
        logic [1:0] stage;
        logic [1:0] wslot;
    } t_calc_ctl;

    // Signed shift: positive amount shifts right, zero or negative shifts left
    function automatic logic [DATA_W-1:0] sshift(input logic [DATA_W-1:0] v,
                                                 input logic signed [SHIFT_W-1:0] amt);
        logic [SHIFT_W-1:0] mag;
        logic [DATA_W-1:0]  res;
        mag = ~amt + 1'b1;
        if (!amt[SHIFT_W-1] && (amt != '0)) begin
            res = v >> amt[SHIFT_W-2:0];
        end else if (mag[SHIFT_W-1]) begin
            res = '0;
        end else begin
            res = v << mag[SHIFT_W-2:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gwsr_store.sv -----
`default_nettype none

// Word store: circular buffer over one synchronous RAM, with a base pointer
// for the one-word move and per-entry valid bits so cleared words read zero.
module gwsr_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gwsr_pkg::t_store_ctl          i_ctl,
    output logic [gwsr_pkg::DATA_W-1:0]        o_rdata
);

    logic [gwsr_pkg::DATA_W-1:0] r_mem [gwsr_pkg::MAX_WORDS];
    logic [gwsr_pkg::DATA_W-1:0] r_q;
    logic                        r_rd_zero;
    logic [gwsr_pkg::MAX_WORDS-1:0] r_valid;
    logic [gwsr_pkg::ADDR_W-1:0] r_base;

    logic [gwsr_pkg::ADDR_W-1:0] rd_phys;
    logic [gwsr_pkg::ADDR_W-1:0] wr_phys;
    logic                        wr_hit;

    // Map logical word index onto the ring
    assign rd_phys = r_base + i_ctl.rd_idx[gwsr_pkg::ADDR_W-1:0];
    assign wr_phys = r_base + i_ctl.wr_idx[gwsr_pkg::ADDR_W-1:0];
    assign wr_hit  = i_ctl.wr_en && !i_ctl.wr_idx[gwsr_pkg::ADDR_W];

    // RAM write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_phys] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[rd_phys];
        end
    end

    // Base pointer, valid bits and read masking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_base    <= '0;
            r_rd_zero <= 1'b1;
        end else begin
            if (i_ctl.advance) begin
                r_base          <= r_base + 1'b1;
                r_valid[r_base] <= 1'b0;
            end
            if (wr_hit) begin
                r_valid[wr_phys] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_zero <= i_ctl.rd_idx[gwsr_pkg::ADDR_W] || !r_valid[rd_phys];
            end
        end
    end

    assign o_rdata = r_rd_zero ? '0 : r_q;

endmodule

`default_nettype wire

// ----- rtl/core/gwsr_calc.sv -----
`default_nettype none

// Recurrence datapath: tap operand registers and three shift-xor stages.
module gwsr_calc (
    input  wire logic                                i_clk,
    input  wire gwsr_pkg::t_calc_ctl                 i_ctl,
    input  wire logic [gwsr_pkg::DATA_W-1:0]         i_rdata,
    input  wire gwsr_pkg::t_gen                      i_gen_type,
    input  wire logic signed [gwsr_pkg::SHIFT_W-1:0] i_shift_a,
    input  wire logic signed [gwsr_pkg::SHIFT_W-1:0] i_shift_b,
    input  wire logic signed [gwsr_pkg::SHIFT_W-1:0] i_shift_c,
    input  wire logic signed [gwsr_pkg::SHIFT_W-1:0] i_shift_d,
    input  wire logic [gwsr_pkg::DATA_W-1:0]         i_twist_mask,
    output logic [gwsr_pkg::DATA_W-1:0]              o_wr_data
);

    logic [gwsr_pkg::DATA_W-1:0] r_v0, r_vm, r_vn, r_vn1, r_vn2;
    logic [gwsr_pkg::DATA_W-1:0] r_x0, r_x1, r_x2;
    logic [gwsr_pkg::DATA_W-1:0] n_x0, n_x1, n_x2;
    logic [gwsr_pkg::DATA_W-1:0] z1;
    logic [gwsr_pkg::DATA_W-1:0] twist;

    // Capture tap words as they return from the store
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_en) begin
            unique case (i_ctl.cap_tap)
                gwsr_pkg::TAP_V0:  r_v0  <= i_rdata;
                gwsr_pkg::TAP_VM:  r_vm  <= i_rdata;
                gwsr_pkg::TAP_VN:  r_vn  <= i_rdata;
                gwsr_pkg::TAP_VN1: r_vn1 <= i_rdata;
                gwsr_pkg::TAP_VN2: r_vn2 <= i_rdata;
                default: ;
            endcase
        end
    end

    assign twist = r_vn[0] ? i_twist_mask : '0;
    assign z1    = r_x0 ^ r_vm;

    // One shift level per stage
    always_comb begin
        n_x0 = r_x0;
        n_x1 = r_x1;
        n_x2 = r_x2;
        unique case (i_ctl.stage)
            2'd0: begin
                unique case (i_gen_type)
                    gwsr_pkg::GEN_T1: n_x0 = r_vn ^ gwsr_pkg::sshift(r_v0, i_shift_a)
                                               ^ gwsr_pkg::sshift(r_v0, i_shift_b);
                    gwsr_pkg::GEN_T2: begin
                        n_x0 = (r_vn >> 1) ^ gwsr_pkg::sshift(r_vm, i_shift_a)
                               ^ gwsr_pkg::sshift(r_vm, i_shift_b) ^ twist;
                        n_x1 = r_v0 ^ gwsr_pkg::sshift(r_v0, i_shift_c);
                    end
                    gwsr_pkg::GEN_T3: n_x0 = r_vn ^ r_v0 ^ gwsr_pkg::sshift(r_vm, i_shift_a);
                    default: ;
                endcase
            end
            2'd1: begin
                unique case (i_gen_type)
                    gwsr_pkg::GEN_T1: n_x1 = z1 ^ gwsr_pkg::sshift(z1, i_shift_c);
                    gwsr_pkg::GEN_T2: n_x2 = r_x1 ^ gwsr_pkg::sshift(r_x1, i_shift_d);
                    gwsr_pkg::GEN_T3: n_x1 = r_vn1 ^ r_x0 ^ gwsr_pkg::sshift(r_x0, i_shift_b);
                    default: ;
                endcase
            end
            2'd2: begin
                unique case (i_gen_type)
                    gwsr_pkg::GEN_T1: n_x2 = r_v0 ^ r_x1 ^ gwsr_pkg::sshift(r_x1, i_shift_d);
                    gwsr_pkg::GEN_T3: n_x2 = r_vn2 ^ r_x1 ^ gwsr_pkg::sshift(r_x1, i_shift_c);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc_en) begin
            r_x0 <= n_x0;
            r_x1 <= n_x1;
            r_x2 <= n_x2;
        end
    end

    // Select the word for each write slot (slot k lands at index n-1+k)
    always_comb begin
        o_wr_data = r_x0;
        unique case (i_gen_type)
            gwsr_pkg::GEN_T1: o_wr_data = (i_ctl.wslot == 2'd0) ? r_x2 : r_x1;
            gwsr_pkg::GEN_T2: o_wr_data = (i_ctl.wslot == 2'd0) ? r_x0 : r_x2;
            gwsr_pkg::GEN_T3: begin
                unique case (i_ctl.wslot)
                    2'd0: o_wr_data = r_v0 ^ r_x0 ^ r_x1 ^ r_x2;
                    2'd1: o_wr_data = r_x0;
                    2'd2: o_wr_data = r_x1;
                    2'd3: o_wr_data = r_x2;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/gf2_word_shift_register_generator_core.sv -----
`default_nettype none

// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+------------------------------------------
// s_axis    | in  | tvalid / tready      | tdata: load_index[4:0], load_value[36:5];
//           |     |                      | tuser: func (0 step, 1 load)
// m_axis    | out | tvalid / tready      | tdata: top_word[31:0]
// cfg       | in  | we (no wait)         | idx: register, data: value
//
// A load writes its word, then reads word 0 into the output register; a step
// makes five tap reads, three shift-xor stages, four write slots, then that read,
// or with gen_type 0 only the read, through the single read and write port.
// One further item is held at the input while an item is in work, and a result
// waits in the output register without stopping the engine until it must write it.
// Reset clears the store through per-word valid bits; no clearing pass is needed.
module gf2_word_shift_register_generator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: load_index [4:0], load_value [36:5], zero [39:37]
    input  wire logic [gwsr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: func [0]
    input  wire logic                              i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata: top_word [31:0]
    output logic [gwsr_pkg::DATA_W-1:0]            o_m_axis_tdata,
    input  wire logic                              i_cfg_we,
    input  wire logic [gwsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gwsr_pkg::DATA_W-1:0]       i_cfg_data
);

    // Configuration registers
    gwsr_pkg::t_gen                      r_gen_type;
    logic [4:0]                          r_word_count;
    logic [4:0]                          r_middle_tap;
    logic signed [gwsr_pkg::SHIFT_W-1:0] r_shift_a, r_shift_b, r_shift_c, r_shift_d;
    logic [gwsr_pkg::DATA_W-1:0]         r_twist_mask;

    // Input hold and current item
    logic                                r_hold_valid;
    logic                                r_hold_func;
    logic [gwsr_pkg::LOAD_IDX_W-1:0]     r_hold_idx;
    logic [gwsr_pkg::DATA_W-1:0]         r_hold_value;
    logic [gwsr_pkg::LOAD_IDX_W-1:0]     r_cur_idx;
    logic [gwsr_pkg::DATA_W-1:0]         r_cur_value;

    // Output register
    logic                                r_out_valid;
    logic [gwsr_pkg::DATA_W-1:0]         r_out_data;

    // Sequencer
    gwsr_pkg::t_state                    r_state, n_state;
    logic [gwsr_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic                                dispatch;
    logic                                out_load;
    logic                                out_free;
    logic                                s_accept;
    gwsr_pkg::t_store_ctl                st_ctl;
    gwsr_pkg::t_calc_ctl                 calc_ctl;
    gwsr_pkg::t_tap                      rd_tap;
    logic [gwsr_pkg::IDX_W-1:0]          n_ext;
    logic [gwsr_pkg::IDX_W-1:0]          wr_nk;
    logic [gwsr_pkg::DATA_W-1:0]         store_rdata;
    logic [gwsr_pkg::DATA_W-1:0]         calc_wr_data;

    assign o_s_axis_tready = !r_hold_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_type   <= gwsr_pkg::GEN_T1;
            r_word_count <= 5'd2;
            r_middle_tap <= 5'd1;
            r_shift_a    <= '0;
            r_shift_b    <= '0;
            r_shift_c    <= '0;
            r_shift_d    <= '0;
            r_twist_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (gwsr_pkg::t_cfg_reg'(i_cfg_idx))
                gwsr_pkg::CFG_GEN_TYPE:   r_gen_type   <= gwsr_pkg::t_gen'(i_cfg_data[1:0]);
                gwsr_pkg::CFG_WORD_COUNT: r_word_count <= i_cfg_data[4:0];
                gwsr_pkg::CFG_MIDDLE_TAP: r_middle_tap <= i_cfg_data[4:0];
                gwsr_pkg::CFG_SHIFT_A:    r_shift_a    <= i_cfg_data[gwsr_pkg::SHIFT_W-1:0];
                gwsr_pkg::CFG_SHIFT_B:    r_shift_b    <= i_cfg_data[gwsr_pkg::SHIFT_W-1:0];
                gwsr_pkg::CFG_SHIFT_C:    r_shift_c    <= i_cfg_data[gwsr_pkg::SHIFT_W-1:0];
                gwsr_pkg::CFG_SHIFT_D:    r_shift_d    <= i_cfg_data[gwsr_pkg::SHIFT_W-1:0];
                gwsr_pkg::CFG_TWIST_MASK: r_twist_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input hold: take a transaction whenever the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (s_accept) begin
            r_hold_valid <= 1'b1;
        end else if (dispatch) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_hold_func  <= i_s_axis_tuser;
            r_hold_idx   <= i_s_axis_tdata[gwsr_pkg::LOAD_IDX_W-1:0];
            r_hold_value <= i_s_axis_tdata[gwsr_pkg::IN_FIELDS_W-1:gwsr_pkg::LOAD_IDX_W];
        end
        if (dispatch) begin
            r_cur_idx   <= r_hold_idx;
            r_cur_value <= r_hold_value;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= store_rdata;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwsr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign n_ext = {1'b0, r_word_count};
    assign wr_nk = n_ext + gwsr_pkg::IDX_W'(r_cnt[1:0]);
    assign rd_tap = gwsr_pkg::t_tap'(r_cnt);

    // Next state and control for store and datapath
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        dispatch = 1'b0;
        out_load = 1'b0;
        st_ctl   = '0;
        calc_ctl = '0;
        unique case (r_state)
            gwsr_pkg::ST_IDLE: begin
                if (r_hold_valid) begin
                    dispatch = 1'b1;
                    n_cnt    = '0;
                    if (r_hold_func) begin
                        n_state = gwsr_pkg::ST_LOAD;
                    end else if (r_gen_type == gwsr_pkg::GEN_NONE) begin
                        n_state = gwsr_pkg::ST_FETCH;
                    end else begin
                        n_state = gwsr_pkg::ST_READ;
                    end
                end
            end
            gwsr_pkg::ST_LOAD: begin
                st_ctl.wr_en   = 1'b1;
                st_ctl.wr_idx  = {1'b0, r_cur_idx};
                st_ctl.wr_data = r_cur_value;
                n_state        = gwsr_pkg::ST_FETCH;
            end
            gwsr_pkg::ST_READ: begin
                // Issue one tap read a cycle, capture the previous one
                if (r_cnt < gwsr_pkg::CNT_W'(gwsr_pkg::TAP_COUNT)) begin
                    st_ctl.rd_en = 1'b1;
                    unique case (rd_tap)
                        gwsr_pkg::TAP_V0:  st_ctl.rd_idx = '0;
                        gwsr_pkg::TAP_VM:  st_ctl.rd_idx = {1'b0, r_middle_tap};
                        gwsr_pkg::TAP_VN:  st_ctl.rd_idx = n_ext;
                        gwsr_pkg::TAP_VN1: st_ctl.rd_idx = n_ext + gwsr_pkg::IDX_W'(1);
                        gwsr_pkg::TAP_VN2: st_ctl.rd_idx = n_ext + gwsr_pkg::IDX_W'(2);
                        default:           st_ctl.rd_idx = '0;
                    endcase
                end
                if (r_cnt != '0) begin
                    calc_ctl.cap_en  = 1'b1;
                    calc_ctl.cap_tap = gwsr_pkg::t_tap'(r_cnt - 1'b1);
                end
                if (r_cnt == gwsr_pkg::CNT_W'(gwsr_pkg::TAP_COUNT)) begin
                    n_state = gwsr_pkg::ST_CALC;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gwsr_pkg::ST_CALC: begin
                calc_ctl.calc_en = 1'b1;
                calc_ctl.stage   = r_cnt[1:0];
                if (r_cnt == gwsr_pkg::CNT_W'(gwsr_pkg::CALC_STAGES - 1)) begin
                    // Move the store down one word with the last stage
                    st_ctl.advance = 1'b1;
                    n_state        = gwsr_pkg::ST_WRITE;
                    n_cnt          = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gwsr_pkg::ST_WRITE: begin
                // Slot k targets index n-1+k; drop targets below 0 or past the top, and slots 2 and 3 unless type 3
                calc_ctl.wslot = r_cnt[1:0];
                st_ctl.wr_en   = (wr_nk != '0)
                              && (wr_nk <= gwsr_pkg::IDX_W'(gwsr_pkg::MAX_WORDS))
                              && ((r_cnt < gwsr_pkg::CNT_W'(2))
                                  || (r_gen_type == gwsr_pkg::GEN_T3));
                st_ctl.wr_idx  = wr_nk - 1'b1;
                st_ctl.wr_data = calc_wr_data;
                if (r_cnt == gwsr_pkg::CNT_W'(gwsr_pkg::WR_SLOTS - 1)) begin
                    n_state = gwsr_pkg::ST_FETCH;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gwsr_pkg::ST_FETCH: begin
                // Read word 0 once the output register will be free
                if (out_free) begin
                    st_ctl.rd_en  = 1'b1;
                    st_ctl.rd_idx = '0;
                    n_state       = gwsr_pkg::ST_OUT;
                end
            end
            gwsr_pkg::ST_OUT: begin
                out_load = 1'b1;
                n_state  = gwsr_pkg::ST_IDLE;
            end
            default: n_state = gwsr_pkg::ST_IDLE;
        endcase
    end

    gwsr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .o_rdata (store_rdata)
    );

    gwsr_calc u_calc (
        .i_clk        (i_clk),
        .i_ctl        (calc_ctl),
        .i_rdata      (store_rdata),
        .i_gen_type   (r_gen_type),
        .i_shift_a    (r_shift_a),
        .i_shift_b    (r_shift_b),
        .i_shift_c    (r_shift_c),
        .i_shift_d    (r_shift_d),
        .i_twist_mask (r_twist_mask),
        .o_wr_data    (calc_wr_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/gwsr_checker.sv -----
`default_nettype none

// Port-level checks for the generator core
module gwsr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            i_s_axis_tready,
    input wire logic                            i_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [gwsr_pkg::DATA_W-1:0]     i_m_axis_tdata
);

    // Reset leaves the input open and no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_s_axis_tready && !i_m_axis_tvalid))
        else $error("core not idle after reset");

    // An accepted transaction occupies the single input hold slot
    a_hold_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && i_s_axis_tready) |=> !i_s_axis_tready)
        else $error("input taken again before hold slot drained");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind gf2_word_shift_register_generator_core gwsr_checker u_gwsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- dv/gwsr_tb_pkg.sv -----
`default_nettype none

package gwsr_tb_pkg;

    // Input transaction kind, carried on s_axis tuser
    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

endpackage

`default_nettype wire

// ----- dv/gwsr_top_word_checker.sv -----
`default_nettype none

module gwsr_top_word_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    input  wire logic                                 i_s_tready,
    // tdata: load_index [4:0], load_value [36:5], zero [39:37]
    input  wire logic [gwsr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // tuser: func [0]
    input  wire logic                                 i_s_tuser,
    input  wire logic                                 i_m_tvalid,
    input  wire logic                                 i_m_tready,
    // tdata: top_word [31:0]
    input  wire logic [gwsr_pkg::DATA_W-1:0]          i_m_tdata,
    input  wire logic                                 i_cfg_we,
    input  wire logic [gwsr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [gwsr_pkg::DATA_W-1:0]          i_cfg_data,
    output int                                        o_err_count,
    output int                                        o_pending,
    output int                                        o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import gwsr_pkg::*;
    import gwsr_tb_pkg::*;

    // Predictor state: word store and register copies
    logic [DATA_W-1:0]        word_store [MAX_WORDS];
    t_gen                     gen_type_q;
    logic [4:0]               word_count_q;
    logic [4:0]               middle_tap_q;
    logic signed [SHIFT_W-1:0] shift_a_q;
    logic signed [SHIFT_W-1:0] shift_b_q;
    logic signed [SHIFT_W-1:0] shift_c_q;
    logic signed [SHIFT_W-1:0] shift_d_q;
    logic [DATA_W-1:0]        twist_mask_q;

    logic [DATA_W-1:0]        expected_top_words [$];
    logic [DATA_W-1:0]        want_word;
    logic [DATA_W-1:0]        next_word;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_results   = 0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] MISMATCH %s: top_word got %08h want %08h", $time, what, got, want);
        o_err_count++;
    endtask

    // Positive amount shifts right, zero or negative shifts left; a magnitude of 32 or more gives zero
    function automatic logic [DATA_W-1:0] tap_shift(logic [DATA_W-1:0] v, int amt);
        if (amt > 0) begin
            return (amt >= DATA_W) ? '0 : (v >> amt);
        end
        if (-amt >= DATA_W) begin
            return '0;
        end
        return v << (-amt);
    endfunction

    // Taps beyond the store read as zero
    function automatic logic [DATA_W-1:0] word_at(int idx);
        if (idx < 0 || idx >= MAX_WORDS) begin
            return '0;
        end
        return word_store[idx];
    endfunction

    // Writes outside the store are dropped
    function automatic void put_word(int idx, logic [DATA_W-1:0] val);
        if (idx >= 0 && idx < MAX_WORDS) begin
            word_store[idx] = val;
        end
    endfunction

    function automatic void slide_store();
        for (int i = 0; i + 1 < MAX_WORDS; i++) begin
            word_store[i] = word_store[i + 1];
        end
        word_store[MAX_WORDS-1] = '0;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < MAX_WORDS; i++) begin
            word_store[i] = '0;
        end
        gen_type_q   = GEN_T1;
        word_count_q = 5'd2;
        middle_tap_q = 5'd1;
        shift_a_q    = '0;
        shift_b_q    = '0;
        shift_c_q    = '0;
        shift_d_q    = '0;
        twist_mask_q = '0;
    endfunction

    // One generator step with the selected recurrence
    function automatic void advance_generator();
        int n;
        int m;
        int a;
        int b;
        int c;
        int d;
        logic [DATA_W-1:0] v0;
        logic [DATA_W-1:0] vm;
        logic [DATA_W-1:0] vn;
        logic [DATA_W-1:0] z0;
        logic [DATA_W-1:0] z1;
        logic [DATA_W-1:0] z2;
        logic [DATA_W-1:0] z3;
        logic [DATA_W-1:0] u;
        n  = int'(word_count_q);
        m  = int'(middle_tap_q);
        a  = int'(shift_a_q);
        b  = int'(shift_b_q);
        c  = int'(shift_c_q);
        d  = int'(shift_d_q);
        v0 = word_at(0);
        case (gen_type_q)
            GEN_T1: begin
                z0 = word_at(n) ^ tap_shift(v0, a) ^ tap_shift(v0, b);
                z1 = z0 ^ word_at(m);
                z2 = z1 ^ tap_shift(z1, c);
                z3 = v0 ^ z2 ^ tap_shift(z2, d);
                slide_store();
                put_word(n - 1, z3);
                put_word(n, z2);
            end
            GEN_T2: begin
                vm = word_at(m);
                vn = word_at(n);
                z0 = (vn >> 1) ^ tap_shift(vm, a) ^ tap_shift(vm, b);
                if (vn[0]) begin
                    z0 = z0 ^ twist_mask_q;
                end
                u  = v0 ^ tap_shift(v0, c);
                z1 = u ^ tap_shift(u, d);
                slide_store();
                put_word(n - 1, z0);
                put_word(n, z1);
            end
            GEN_T3: begin
                z0 = word_at(n) ^ v0 ^ tap_shift(word_at(m), a);
                z1 = word_at(n + 1) ^ z0 ^ tap_shift(z0, b);
                z2 = word_at(n + 2) ^ z1 ^ tap_shift(z1, c);
                slide_store();
                put_word(n - 1, v0 ^ z0 ^ z1 ^ z2);
                put_word(n, z0);
                put_word(n + 1, z1);
                put_word(n + 2, z2);
            end
            default: begin
                // unused type: store holds
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] predict_top_word(logic func,
                                                           logic [LOAD_IDX_W-1:0] idx,
                                                           logic [DATA_W-1:0] val);
        if (func == FUNC_LOAD) begin
            put_word(int'(idx), val);
        end else begin
            advance_generator();
        end
        return word_store[0];
    endfunction

    function automatic void write_register(t_cfg_reg idx, logic [DATA_W-1:0] val);
        case (idx)
            CFG_GEN_TYPE:   gen_type_q   = t_gen'(val[GEN_W-1:0]);
            CFG_WORD_COUNT: word_count_q = val[4:0];
            CFG_MIDDLE_TAP: middle_tap_q = val[4:0];
            CFG_SHIFT_A:    shift_a_q    = val[SHIFT_W-1:0];
            CFG_SHIFT_B:    shift_b_q    = val[SHIFT_W-1:0];
            CFG_SHIFT_C:    shift_c_q    = val[SHIFT_W-1:0];
            CFG_SHIFT_D:    shift_d_q    = val[SHIFT_W-1:0];
            CFG_TWIST_MASK: twist_mask_q = val;
            default: begin
            end
        endcase
    endfunction

    // Compare results first, then track register writes and predict new transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            expected_top_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                if (expected_top_words.size() == 0) begin
                    report_mismatch("result with nothing pending", i_m_tdata, '0);
                end else begin
                    want_word = expected_top_words.pop_front();
                    if (i_m_tdata !== want_word) begin
                        report_mismatch("wrong value", i_m_tdata, want_word);
                    end
                end
            end
            if (i_cfg_we) begin
                write_register(t_cfg_reg'(i_cfg_idx), i_cfg_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                next_word = predict_top_word(i_s_tuser,
                                             i_s_tdata[LOAD_IDX_W-1:0],
                                             i_s_tdata[LOAD_IDX_W +: DATA_W]);
                expected_top_words = {expected_top_words, next_word};
            end
        end
        o_pending = expected_top_words.size();
    end

endmodule

`default_nettype wire

// ----- dv/gf2_word_shift_register_generator_core_tb.sv -----
`default_nettype none

module gf2_word_shift_register_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gwsr_pkg::*;
    import gwsr_tb_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RESET_CYCLES    = 12;
    localparam int          IDLE_PCT        = 29;
    localparam int          RANDOM_PHASES   = 10;
    localparam int          ITEMS_PER_PHASE = 115;
    localparam int          CALM_PHASE      = 4;
    localparam int          TAIL_CYCLES     = 40;
    localparam int unsigned TIMEOUT_NS      = 3_000_000;

    typedef struct packed {
        t_gen               gen;
        logic [4:0]         n;
        logic [4:0]         m;
        logic [SHIFT_W-1:0] a;
        logic [SHIFT_W-1:0] b;
        logic [SHIFT_W-1:0] c;
        logic [SHIFT_W-1:0] d;
        logic [DATA_W-1:0]  mask;
    } t_gen_setting;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [DATA_W-1:0]     i_cfg_data      = '0;
    wire logic             o_s_axis_tready;
    wire logic             o_m_axis_tvalid;
    wire logic [DATA_W-1:0] o_m_axis_tdata;

    int          err_count;
    int          pending;
    int          results;
    bit          calm = 1'b0;
    int unsigned n_loads = 0;
    int unsigned n_steps = 0;
    int unsigned n_settings = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    gf2_word_shift_register_generator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    gwsr_top_word_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_results   (results)
    );

    // Stall the result channel at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_item(logic func, logic [LOAD_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= func;
        i_s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (func == FUNC_LOAD) begin
            n_loads++;
        end else begin
            n_steps++;
        end
    endtask

    task automatic load_word(logic [LOAD_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        send_item(FUNC_LOAD, idx, val);
    endtask

    // Index and value are don't-care on a step; drive them random anyway
    task automatic step_gen();
        send_item(FUNC_STEP, LOAD_IDX_W'($urandom), $urandom);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Write every register back to back while the block is idle
    task automatic apply_setting(t_gen_setting s);
        @(posedge i_clk);
        write_reg(CFG_GEN_TYPE,   DATA_W'(s.gen));
        write_reg(CFG_WORD_COUNT, DATA_W'(s.n));
        write_reg(CFG_MIDDLE_TAP, DATA_W'(s.m));
        write_reg(CFG_SHIFT_A,    DATA_W'(s.a));
        write_reg(CFG_SHIFT_B,    DATA_W'(s.b));
        write_reg(CFG_SHIFT_C,    DATA_W'(s.c));
        write_reg(CFG_SHIFT_D,    DATA_W'(s.d));
        write_reg(CFG_TWIST_MASK, s.mask);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_gen_setting setting(t_gen g, logic [4:0] n, logic [4:0] m,
                                             logic [SHIFT_W-1:0] a, logic [SHIFT_W-1:0] b,
                                             logic [SHIFT_W-1:0] c, logic [SHIFT_W-1:0] d,
                                             logic [DATA_W-1:0] mask);
        t_gen_setting s;
        s.gen  = g;
        s.n    = n;
        s.m    = m;
        s.a    = a;
        s.b    = b;
        s.c    = c;
        s.d    = d;
        s.mask = mask;
        return s;
    endfunction

    // Favor the shift extremes: left by 32, right by 31, left by 31 and zero
    function automatic logic [SHIFT_W-1:0] rand_shift();
        case ($urandom_range(0, 7))
            0:       return 6'h20;
            1:       return 6'd31;
            2:       return 6'h21;
            3:       return 6'd0;
            default: return SHIFT_W'($urandom);
        endcase
    endfunction

    function automatic t_gen_setting rand_setting();
        t_gen_setting s;
        case ($urandom_range(0, 9))
            0:       s.gen = GEN_NONE;
            1, 2, 3: s.gen = GEN_T1;
            4, 5, 6: s.gen = GEN_T2;
            default: s.gen = GEN_T3;
        endcase
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0:       s.n = 5'd0;
                1:       s.n = 5'd1;
                2:       s.n = 5'd30;
                default: s.n = 5'd31;
            endcase
        end else begin
            s.n = 5'($urandom_range(2, 29));
        end
        if (s.n >= 5'd2 && $urandom_range(0, 5) != 0) begin
            s.m = 5'($urandom_range(1, int'(s.n) - 1));
        end else begin
            s.m = 5'($urandom);
        end
        s.a    = rand_shift();
        s.b    = rand_shift();
        s.c    = rand_shift();
        s.d    = rand_shift();
        s.mask = $urandom;
        return s;
    endfunction

    // Seed the active words in order, then mostly steps with some stray loads
    task automatic random_phase(t_gen_setting s, int count);
        int seeds;
        int sent;
        int r;
        seeds = int'(s.n) + 3;
        if (seeds > MAX_WORDS) begin
            seeds = MAX_WORDS;
        end
        for (int i = 0; i < seeds; i++) begin
            load_word(LOAD_IDX_W'(i), $urandom);
        end
        sent = seeds;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                step_gen();
            end else if (r < 93) begin
                load_word(LOAD_IDX_W'($urandom), $urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0:       load_word(LOAD_IDX_W'($urandom), 32'h0000_0000);
                    1:       load_word(LOAD_IDX_W'($urandom), 32'hFFFF_FFFF);
                    2:       load_word(LOAD_IDX_W'($urandom), 32'h0000_0001);
                    default: load_word(LOAD_IDX_W'($urandom), 32'h8000_0000);
                endcase
            end
            sent++;
        end
    endtask

    initial begin
        t_gen_setting s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: step on an empty store, loads at both ends
        step_gen();
        load_word(5'd0, 32'hFFFF_FFFF);
        load_word(5'd31, 32'h8000_0001);
        load_word(5'd2, 32'hA5A5_A5A5);
        step_gen();
        step_gen();

        // Type 1 at the top of the store, shift by 32 and by 31
        drain();
        apply_setting(setting(GEN_T1, 5'd31, 5'd28, 6'h20, 6'd31, 6'h21, 6'd1, 32'h0));
        load_word(5'd0, 32'hFFFF_0000);
        load_word(5'd28, 32'h0F0F_0F0F);
        load_word(5'd31, 32'hFFFF_FFFF);
        step_gen();
        step_gen();

        // Type 2 with word count 0: target below the store, twist on odd word
        drain();
        apply_setting(setting(GEN_T2, 5'd0, 5'd31, 6'h3F, 6'd0, 6'd31, 6'h20, 32'hFFFF_FFFF));
        load_word(5'd0, 32'h0000_0001);
        step_gen();
        step_gen();

        // Type 3 with taps and targets beyond the store
        drain();
        apply_setting(setting(GEN_T3, 5'd31, 5'd0, 6'd1, 6'h3F, 6'h20, 6'd31, 32'h0));
        load_word(5'd0, 32'hDEAD_BEEF);
        load_word(5'd31, 32'h1357_9BDF);
        step_gen();
        step_gen();

        // Unused type: store holds on a step
        drain();
        apply_setting(setting(GEN_NONE, 5'd2, 5'd1, 6'd0, 6'd0, 6'd0, 6'd0, 32'h0));
        load_word(5'd0, 32'hCAFE_F00D);
        step_gen();
        step_gen();

        // Type 2 at the upper word count with a typical twist mask
        drain();
        apply_setting(setting(GEN_T2, 5'd29, 5'd1, 6'h21, 6'd31, 6'h3B, 6'd7, 32'h9908_B0DF));
        load_word(5'd29, 32'h0000_0003);
        load_word(5'd1, 32'hFFFF_FFFF);
        step_gen();

        // Random settings, one stretch without idling on either side
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            calm = (phase == CALM_PHASE);
            s = rand_setting();
            apply_setting(s);
            random_phase(s, ITEMS_PER_PHASE);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d step and %0d load transactions over %0d register settings,",
                 n_steps, n_loads, n_settings);
        $display("types 0 to 3 and word counts up to the store edge; %0d results checked.",
                 results);
        if (err_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still pending", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/gwsr_pkg.sv
rtl/core/gwsr_store.sv
rtl/core/gwsr_calc.sv
rtl/core/gf2_word_shift_register_generator_core.sv
rtl/core/gwsr_checker.sv
dv/gwsr_tb_pkg.sv
dv/gwsr_top_word_checker.sv
dv/gf2_word_shift_register_generator_core_tb.sv
